// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define FRA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/fra_pkg.sv -----
// ----------------------------------------------------------------------------
// fra_pkg
// shared widths, codes and types of the fenced ring allocator
// ----------------------------------------------------------------------------
package fra_pkg;

   localparam int OFF_W   = 29;
   localparam int SIZE_W  = 29;
   localparam int ALIGN_W = 17;
   localparam int FENCE_W = 64;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 8;

   localparam int FENCE_DEPTH_DEF = 16;

   localparam logic [SIZE_W-1:0] SIZE_LIMIT_RST = SIZE_W'(268435456);
   localparam logic [SIZE_W-1:0] START_SIZE_RST = SIZE_W'(4194304);

   localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
   localparam logic [OP_W-1:0] OP_MARKER   = 2'd1;
   localparam logic [OP_W-1:0] OP_OVERRIDE = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_QFULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SIZE = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_TRY,
      ST_RET_WAIT,
      ST_RET_CHK,
      ST_TRY2,
      ST_GROW,
      ST_SCAN_WAIT,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fq_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fq_status_type;

endpackage

// ----- hw/rtl/fenced_ring_allocator.sv -----
// ----------------------------------------------------------------------------
// fenced_ring_allocator
// ring buffer range allocator with fence based retirement of consumed space
// ----------------------------------------------------------------------------
// req channel: tuser carries the operation (allocate, queue fence marker,
// override the size of the previous allocation), tdata the request fields.
// rsp channel: one transaction per request with the offset, the fence to
// wait on, the buffer size and flush/grow/status flags.
// csr channel: writes the size limit (index 0); a write to the start size
// (index 1) is taken but has no effect, as reset loads the default size.
// marker, override, unused and oversize requests go straight to the final
// state; an allocate with a nonzero alignment first runs the alignment
// remainder one bit per cycle in the serial remainder unit, and where the
// first try fails each queued fence is visited once, by either the retire
// walk or the wait walk, through the registered fence queue read port, plus
// one closing check of each walk.
// req_tready is high only while idle; a new request can be taken while the
// previous response still waits, and a stalled rsp side holds the block in
// its final state until the response register is free.
// reset empties the fence queue, zeroes the offsets and loads the default
// buffer size; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fenced_ring_allocator #(
   parameter int FENCE_DEPTH = fra_pkg::FENCE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // alloc_size[28:0], alignment[45:29], marker_fence[109:46],
   // completed_fence[173:110], zero fill
   input  logic [175:0]                   req_tdata,
   // operation[1:0]
   input  logic [fra_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // alloc_offset[28:0], wait_fence[92:29], current_size[121:93], zero fill
   output logic [127:0]                   rsp_tdata,
   // flushed[0], reallocated[1], status[3:2]
   output logic [3:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fra_pkg::SIZE_W-1:0]     csr_data
);

   localparam int OW = fra_pkg::OFF_W;
   localparam int FW = fra_pkg::FENCE_W;

   fra_pkg::state_type state_ff, state_in;

   logic [fra_pkg::SIZE_W-1:0]  max_ff, max_in;
   logic [OW-1:0]               wo_ff, wo_in;
   logic [OW-1:0]               as_ff, as_in;
   logic [OW-1:0]               co_ff, co_in;
   logic [fra_pkg::SIZE_W-1:0]  bs_ff, bs_in;

   logic [fra_pkg::SIZE_W-1:0]  a_ff, a_in;
   logic [fra_pkg::ALIGN_W-1:0] align_ff, align_in;
   logic [FW-1:0]               cfence_ff, cfence_in;
   logic [FW-1:0]               wait_ff, wait_in;
   logic                        flush_ff, flush_in;
   logic                        grew_ff, grew_in;
   logic [fra_pkg::STAT_W-1:0]  status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [127:0]                rsp_data_ff, rsp_data_in;
   logic [3:0]                  rsp_user_ff, rsp_user_in;

   logic [fra_pkg::SIZE_W-1:0]  req_a;
   logic [fra_pkg::ALIGN_W-1:0] req_align;
   logic [FW-1:0]               req_marker;
   logic [FW-1:0]               req_cfence;
   logic                        req_fire;

   fra_pkg::fq_ctrl_type        fq_ctrl;
   fra_pkg::fq_status_type      fq_status;
   logic [FW-1:0]               fq_value;
   logic [OW-1:0]               fq_offset;

   logic                        rem_start;
   logic                        rem_done;
   logic [fra_pkg::ALIGN_W-1:0] rem_value;

   logic [OW:0]                 sum_wa;
   logic                        fit_tail, fit_front, fit_gap;
   logic [OW:0]                 aligned;
   logic [OW:0]                 grow0, grow1, grow2;
   logic                        hit, hit_front;
   logic                        rsp_free;

   assign req_a      = req_tdata[28:0];
   assign req_align  = req_tdata[45:29];
   assign req_marker = req_tdata[109:46];
   assign req_cfence = req_tdata[173:110];
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == fra_pkg::ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   fra_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (wo_ff),
      .divisor   (req_align),
      .done      (rem_done),
      .remainder (rem_value)
   );

   fra_fence_queue #(
      .FENCE_DEPTH (FENCE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fq_ctrl),
      .wr_value  (req_marker),
      .wr_offset (wo_ff),
      .status    (fq_status),
      .rd_value  (fq_value),
      .rd_offset (fq_offset)
   );

   // placement tests shared by both space attempts
   always_comb begin
      sum_wa    = {1'b0, wo_ff} + {1'b0, a_ff};
      fit_tail  = (wo_ff >= co_ff) && (sum_wa <= {1'b0, bs_ff});
      fit_front = (wo_ff >= co_ff) && (a_ff < co_ff);
      fit_gap   = (wo_ff < co_ff) && (sum_wa < {1'b0, co_ff});
      aligned   = {1'b0, wo_ff} + (OW+1)'(align_ff) - (OW+1)'(rem_value);
      grow0     = {1'b0, bs_ff} + {2'b00, bs_ff[fra_pkg::SIZE_W-1:1]};
      grow1     = (grow0 > {1'b0, max_ff}) ? {1'b0, max_ff} : grow0;
      grow2     = (grow1 < {1'b0, a_ff}) ? {1'b0, a_ff} : grow1;
      hit_front = 1'b1;
      if (wo_ff >= co_ff) begin
         hit = (fq_offset >= a_ff);
      end else if (sum_wa <= {1'b0, bs_ff}) begin
         hit       = ({1'b0, fq_offset} >= sum_wa);
         hit_front = 1'b0;
      end else begin
         hit = (fq_offset >= a_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      max_in       = max_ff;
      wo_in        = wo_ff;
      as_in        = as_ff;
      co_in        = co_ff;
      bs_in        = bs_ff;
      a_in         = a_ff;
      align_in     = align_ff;
      cfence_in    = cfence_ff;
      wait_in      = wait_ff;
      flush_in     = flush_ff;
      grew_in      = grew_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      fq_ctrl      = '0;
      rem_start    = 1'b0;

      if (csr_valid && (csr_index == fra_pkg::CSR_SIZE_LIMIT)) begin
         max_in = csr_data;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         fra_pkg::ST_IDLE: begin
            if (req_fire) begin
               a_in      = req_a;
               align_in  = req_align;
               cfence_in = req_cfence;
               wait_in   = '0;
               flush_in  = 1'b0;
               grew_in   = 1'b0;
               status_in = fra_pkg::STATUS_OK;
               state_in  = fra_pkg::ST_DONE;
               unique case (req_tuser)
                  fra_pkg::OP_ALLOC: begin
                     if (req_a > max_ff) begin
                        status_in = fra_pkg::STATUS_OVERSIZE;
                     end else if (req_align != '0) begin
                        rem_start = 1'b1;
                        state_in  = fra_pkg::ST_MOD;
                     end else begin
                        state_in = fra_pkg::ST_TRY;
                     end
                  end
                  fra_pkg::OP_MARKER: begin
                     if (fq_status.full) begin
                        status_in = fra_pkg::STATUS_QFULL;
                     end else begin
                        fq_ctrl.push = 1'b1;
                     end
                  end
                  fra_pkg::OP_OVERRIDE: begin
                     wo_in = OW'({1'b0, as_ff} + {1'b0, req_a});
                  end
                  default: begin
                  end
               endcase
            end
         end
         fra_pkg::ST_MOD: begin
            if (rem_done) begin
               if (rem_value != '0) begin
                  if (aligned > {1'b0, bs_ff}) begin
                     wo_in = '0;
                     if (co_ff == '0) begin
                        co_in = OW'(1);
                     end
                  end else begin
                     wo_in = aligned[OW-1:0];
                  end
               end
               state_in = fra_pkg::ST_TRY;
            end
         end
         fra_pkg::ST_TRY, fra_pkg::ST_TRY2: begin
            if (fit_tail || fit_gap) begin
               as_in    = wo_ff;
               wo_in    = sum_wa[OW-1:0];
               state_in = fra_pkg::ST_DONE;
            end else if (fit_front) begin
               as_in    = '0;
               wo_in    = a_ff;
               state_in = fra_pkg::ST_DONE;
            end else if (state_ff == fra_pkg::ST_TRY) begin
               state_in = fra_pkg::ST_RET_WAIT;
            end else begin
               state_in = fra_pkg::ST_GROW;
            end
         end
         fra_pkg::ST_RET_WAIT: begin
            state_in = fra_pkg::ST_RET_CHK;
         end
         fra_pkg::ST_RET_CHK: begin
            // retire every fence the consumer has passed
            if (!fq_status.empty && (cfence_ff > fq_value)) begin
               co_in       = fq_offset;
               fq_ctrl.pop = 1'b1;
               state_in    = fra_pkg::ST_RET_WAIT;
            end else begin
               state_in = fra_pkg::ST_TRY2;
            end
         end
         fra_pkg::ST_GROW: begin
            if (grow2 > {1'b0, bs_ff}) begin
               bs_in    = grow2[fra_pkg::SIZE_W-1:0];
               as_in    = '0;
               wo_in    = a_ff;
               grew_in  = 1'b1;
               state_in = fra_pkg::ST_DONE;
            end else begin
               state_in = fra_pkg::ST_SCAN_WAIT;
            end
         end
         fra_pkg::ST_SCAN_WAIT: begin
            state_in = fra_pkg::ST_SCAN_CHK;
         end
         fra_pkg::ST_SCAN_CHK: begin
            // a hit on a zero fence cannot be waited on, so it flushes
            if (!fq_status.empty && !(hit && (fq_value != '0))) begin
               fq_ctrl.pop = 1'b1;
               state_in    = hit ? fra_pkg::ST_DONE : fra_pkg::ST_SCAN_WAIT;
               if (hit) begin
                  wo_in    = a_ff;
                  as_in    = '0;
                  co_in    = '0;
                  flush_in = 1'b1;
               end
            end else if (!fq_status.empty) begin
               fq_ctrl.pop = 1'b1;
               wait_in     = fq_value;
               state_in    = fra_pkg::ST_DONE;
               if (hit_front) begin
                  as_in = '0;
                  wo_in = a_ff;
               end else begin
                  as_in = wo_ff;
                  wo_in = sum_wa[OW-1:0];
               end
            end else begin
               wo_in    = a_ff;
               as_in    = '0;
               co_in    = '0;
               flush_in = 1'b1;
               state_in = fra_pkg::ST_DONE;
            end
         end
         fra_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, bs_ff, wait_ff, as_ff};
               rsp_user_in  = {status_ff, grew_ff, flush_ff};
               state_in     = fra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fra_pkg::ST_IDLE;
         max_ff       <= fra_pkg::SIZE_LIMIT_RST;
         wo_ff        <= '0;
         as_ff        <= '0;
         co_ff        <= '0;
         bs_ff        <= fra_pkg::START_SIZE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         wo_ff        <= wo_in;
         as_ff        <= as_in;
         co_ff        <= co_in;
         bs_ff        <= bs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      align_ff    <= align_in;
      cfence_ff   <= cfence_in;
      wait_ff     <= wait_in;
      flush_ff    <= flush_in;
      grew_ff     <= grew_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "assert_macros.svh"

   `FRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready,
      "request accepted but block ready again next cycle")
   `FRA_ASSERT_NOW(a_oversize_clean, clock, reset,
      rsp_tvalid && (rsp_tuser[3:2] == fra_pkg::STATUS_OVERSIZE),
      !rsp_tuser[0] && !rsp_tuser[1], "oversize response reports flush or growth")
   `FRA_ASSERT_NOW(a_wait_no_flush, clock, reset,
      rsp_tvalid && (rsp_tdata[92:29] != '0), !rsp_tuser[0] && !rsp_tuser[1],
      "fence wait reported together with flush or growth")

endmodule

// ----- hw/rtl/fra_rem_unit.sv -----
// ----------------------------------------------------------------------------
// fra_rem_unit
// bit-serial restoring remainder of the write offset by the alignment
// ----------------------------------------------------------------------------
module fra_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fra_pkg::OFF_W-1:0]    dividend,
   input  logic [fra_pkg::ALIGN_W-1:0]  divisor,
   output logic                         done,
   output logic [fra_pkg::ALIGN_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(fra_pkg::OFF_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [fra_pkg::OFF_W-1:0]   dvd_ff, dvd_in;
   logic [fra_pkg::ALIGN_W-1:0] div_ff, div_in;
   logic [fra_pkg::ALIGN_W-1:0] rem_ff, rem_in;
   logic [fra_pkg::ALIGN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[fra_pkg::OFF_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(fra_pkg::OFF_W);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (trial >= {1'b0, div_ff}) begin
            rem_in = fra_pkg::ALIGN_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[fra_pkg::ALIGN_W-1:0];
         end
         dvd_in = {dvd_ff[fra_pkg::OFF_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/fra_fence_queue.sv -----
// ----------------------------------------------------------------------------
// fra_fence_queue
// circular queue of (fence, offset) pairs with a registered head read
// ----------------------------------------------------------------------------
module fra_fence_queue #(
   parameter int FENCE_DEPTH = fra_pkg::FENCE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fra_pkg::fq_ctrl_type          ctrl,
   input  logic [fra_pkg::FENCE_W-1:0]   wr_value,
   input  logic [fra_pkg::OFF_W-1:0]     wr_offset,
   output fra_pkg::fq_status_type        status,
   output logic [fra_pkg::FENCE_W-1:0]   rd_value,
   output logic [fra_pkg::OFF_W-1:0]     rd_offset
);

   localparam int HEAD_W = (FENCE_DEPTH > 1) ? $clog2(FENCE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FENCE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   logic [fra_pkg::FENCE_W-1:0] value_mem [FENCE_DEPTH];
   logic [fra_pkg::OFF_W-1:0]   offset_mem [FENCE_DEPTH];

   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  tail_sum;
   logic [HEAD_W-1:0] tail;
   logic [fra_pkg::FENCE_W-1:0] rd_value_ff;
   logic [fra_pkg::OFF_W-1:0]   rd_offset_ff;

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(FENCE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(FENCE_DEPTH);
      end
      tail = tail_sum[HEAD_W-1:0];

      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
         head_in  = (head_ff == HEAD_W'(FENCE_DEPTH - 1)) ? '0 : head_ff + HEAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         value_mem[tail]  <= wr_value;
         offset_mem[tail] <= wr_offset;
      end
      rd_value_ff  <= value_mem[head_ff];
      rd_offset_ff <= offset_mem[head_ff];
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(FENCE_DEPTH));
   assign rd_value     = rd_value_ff;
   assign rd_offset    = rd_offset_ff;

endmodule
